// File: rtl/button_event_detector_top_assert.svh
// ---------------------------------------------------------------------------
// Button event detector assertion macros
// Concurrent checks that vanish from synthesis builds.
// ---------------------------------------------------------------------------
`ifndef BUTTON_EVENT_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_EVENT_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BED_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("button event detector check failed");
// Condition must never be true outside reset.
`define BED_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond) \
	`BED_ASSERT(lbl, clk_sig, rst_n_sig, !(cond))
`else
`define BED_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define BED_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond)
`endif

`endif

// File: rtl/bed_pkg.sv
// ---------------------------------------------------------------------------
// Button event detector package
// Shared types, register indexes and event codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int FEATURE_W   = 6;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_TIMEOUT     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_RATE       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_THRESHOLD    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONGER_THRESHOLD  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONGEST_THRESHOLD = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_ENABLES   = 3'd7;

	localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_TICKS    = 8'd5;
	localparam logic [CFG_DATA_W-1:0] RST_CLICK_TIMEOUT     = 8'd30;
	localparam logic [CFG_DATA_W-1:0] RST_REPEAT_DELAY      = 8'd50;
	localparam logic [CFG_DATA_W-1:0] RST_REPEAT_RATE       = 8'd10;
	localparam logic [CFG_DATA_W-1:0] RST_LONG_THRESHOLD    = 8'd100;
	localparam logic [CFG_DATA_W-1:0] RST_LONGER_THRESHOLD  = 8'd150;
	localparam logic [CFG_DATA_W-1:0] RST_LONGEST_THRESHOLD = 8'd200;
	localparam logic [FEATURE_W-1:0]  RST_FEATURE_ENABLES   = 6'h3F;

	// Bit positions in the feature enable mask.
	localparam int EN_DEBOUNCE = 0;
	localparam int EN_EDGES    = 1;
	localparam int EN_SINGLE   = 2;
	localparam int EN_LONG     = 3;
	localparam int EN_REPEAT   = 4;
	localparam int EN_MULTI    = 5;

	localparam logic [1:0] CLASS_NONE    = 2'd0;
	localparam logic [1:0] CLASS_LONG    = 2'd1;
	localparam logic [1:0] CLASS_LONGER  = 2'd2;
	localparam logic [1:0] CLASS_LONGEST = 2'd3;

	localparam logic [1:0] TALLY_MAX = 2'd3;

	typedef enum logic [1:0] {
		PH_REL    = 2'd0,
		PH_PRS    = 2'd1,
		PH_REL_DB = 2'd2,
		PH_PRS_DB = 2'd3
	} phase_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] debounce_ticks;
		logic [CFG_DATA_W-1:0] click_timeout;
		logic [CFG_DATA_W-1:0] repeat_delay;
		logic [CFG_DATA_W-1:0] repeat_rate;
		logic [CFG_DATA_W-1:0] long_threshold;
		logic [CFG_DATA_W-1:0] longer_threshold;
		logic [CFG_DATA_W-1:0] longest_threshold;
		logic [FEATURE_W-1:0]  feature_enables;
	} cfg_t;

	typedef struct packed {
		logic       rising_edge;
		logic       falling_edge;
		logic       short_press;
		logic [1:0] hold_mark;
		logic [1:0] long_release;
		logic       repeat_press;
		logic [1:0] click_event;
		logic       stable_level;
	} event_t;

endpackage

`default_nettype wire

// File: rtl/bed_cfg_regs.sv
// ---------------------------------------------------------------------------
// Button event detector configuration registers
// Register file written one beat at a time through the index/data port.
// ---------------------------------------------------------------------------
`default_nettype none

module bed_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [bed_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [bed_pkg::CFG_DATA_W-1:0]  wr_data,
	output bed_pkg::cfg_t                cfg
);
	import bed_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= RST_DEBOUNCE_TICKS;
			cfg_q.click_timeout     <= RST_CLICK_TIMEOUT;
			cfg_q.repeat_delay      <= RST_REPEAT_DELAY;
			cfg_q.repeat_rate       <= RST_REPEAT_RATE;
			cfg_q.long_threshold    <= RST_LONG_THRESHOLD;
			cfg_q.longer_threshold  <= RST_LONGER_THRESHOLD;
			cfg_q.longest_threshold <= RST_LONGEST_THRESHOLD;
			cfg_q.feature_enables   <= RST_FEATURE_ENABLES;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_DEBOUNCE_TICKS:    cfg_q.debounce_ticks    <= wr_data;
				CFG_CLICK_TIMEOUT:     cfg_q.click_timeout     <= wr_data;
				CFG_REPEAT_DELAY:      cfg_q.repeat_delay      <= wr_data;
				CFG_REPEAT_RATE:       cfg_q.repeat_rate       <= wr_data;
				CFG_LONG_THRESHOLD:    cfg_q.long_threshold    <= wr_data;
				CFG_LONGER_THRESHOLD:  cfg_q.longer_threshold  <= wr_data;
				CFG_LONGEST_THRESHOLD: cfg_q.longest_threshold <= wr_data;
				CFG_FEATURE_ENABLES:   cfg_q.feature_enables   <= wr_data[FEATURE_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/bed_engine.sv
// ---------------------------------------------------------------------------
// Button event detector engine
// Debounce, hold, repeat and click state with the per-tick event logic.
// ---------------------------------------------------------------------------
`default_nettype none

module bed_engine #(
	parameter int TIMER_WIDTH = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            raw,
	input  bed_pkg::cfg_t   cfg,
	output bed_pkg::event_t ev
);
	import bed_pkg::*;

	localparam int TW = TIMER_WIDTH;
	// Width at which hold counts are compared with the 8-bit thresholds.
	localparam int CW = (TW > CFG_DATA_W) ? TW : CFG_DATA_W;

	phase_t          phase_q, ph, phase_n;
	logic [TW-1:0]   debounce_q, dc;
	logic [TW-1:0]   hold_q, hold_n;
	logic [TW-1:0]   repeat_q, repeat_n, repeat_dec;
	logic [TW-1:0]   click_q, click_n;
	logic [1:0]      tally_q, tally_n;
	logic            db_busy;
	logic            press_target;
	logic            pressed, held, released;
	logic [FEATURE_W-1:0] en;
	event_t          ev_c;

	assign en = cfg.feature_enables;

	// Debounce step.
	always_comb begin
		ph           = phase_q;
		dc           = debounce_q;
		db_busy      = 1'b0;
		press_target = 1'b0;
		if (en[EN_DEBOUNCE]) begin
			if (ph == PH_REL && raw) begin
				ph = PH_PRS_DB;
				dc = TW'(cfg.debounce_ticks);
			end else if (ph == PH_PRS && !raw) begin
				ph = PH_REL_DB;
				dc = TW'(cfg.debounce_ticks);
			end
			if (ph == PH_PRS_DB || ph == PH_REL_DB) begin
				press_target = (ph == PH_PRS_DB);
				if (raw == press_target) begin
					if (dc != '0) begin
						dc      = dc - TW'(1);
						db_busy = 1'b1;
					end else begin
						ph = press_target ? PH_REL : PH_PRS;
					end
				end else begin
					ph      = press_target ? PH_REL : PH_PRS;
					db_busy = 1'b1;
				end
			end
		end
	end

	assign pressed    = !db_busy && ph == PH_REL && raw;
	assign held       = !db_busy && ph == PH_PRS && raw;
	assign released   = !db_busy && ph == PH_PRS && !raw;
	assign repeat_dec = repeat_q - TW'(1);

	// Edge, hold, repeat and click work for a tick that is not debouncing.
	always_comb begin
		ev_c     = '0;
		hold_n   = hold_q;
		repeat_n = repeat_q;
		click_n  = click_q;
		tally_n  = tally_q;
		phase_n  = ph;
		if (!db_busy) begin
			if (pressed) begin
				if (en[EN_MULTI]) click_n = TW'(cfg.click_timeout);
				if (en[EN_EDGES]) ev_c.rising_edge = 1'b1;
				if (en[EN_LONG]) hold_n = '0;
				if (en[EN_REPEAT]) begin
					ev_c.repeat_press = 1'b1;
					repeat_n          = TW'(cfg.repeat_delay);
				end
			end
			if (held) begin
				if (en[EN_MULTI]) click_n = TW'(cfg.click_timeout);
				if (en[EN_LONG] && hold_q != '1) hold_n = hold_q + TW'(1);
				if (en[EN_REPEAT]) begin
					if (repeat_dec == '0) begin
						ev_c.repeat_press = 1'b1;
						repeat_n          = TW'(cfg.repeat_rate);
					end else begin
						repeat_n = repeat_dec;
					end
				end
				if (en[EN_LONG]) begin
					// The lowest matching class wins when thresholds coincide.
					priority if (CW'(hold_n) == CW'(cfg.long_threshold))
						ev_c.hold_mark = CLASS_LONG;
					else if (CW'(hold_n) == CW'(cfg.longer_threshold))
						ev_c.hold_mark = CLASS_LONGER;
					else if (CW'(hold_n) == CW'(cfg.longest_threshold))
						ev_c.hold_mark = CLASS_LONGEST;
					else
						ev_c.hold_mark = CLASS_NONE;
				end
			end
			if (released) begin
				if (en[EN_MULTI]) begin
					click_n = TW'(cfg.click_timeout);
					if (tally_q != TALLY_MAX) tally_n = tally_q + 2'd1;
				end
				if (en[EN_EDGES]) ev_c.falling_edge = 1'b1;
				if (en[EN_LONG]) begin
					priority if (CW'(hold_q) < CW'(cfg.long_threshold))
						ev_c.short_press = 1'b1;
					else if (CW'(hold_q) < CW'(cfg.longer_threshold))
						ev_c.long_release = CLASS_LONG;
					else if (CW'(hold_q) < CW'(cfg.longest_threshold))
						ev_c.long_release = CLASS_LONGER;
					else
						ev_c.long_release = CLASS_LONGEST;
				end else if (en[EN_SINGLE]) begin
					ev_c.short_press = 1'b1;
				end
			end
			if (en[EN_MULTI]) begin
				if (click_n != '0) begin
					click_n = click_n - TW'(1);
				end else begin
					ev_c.click_event = tally_n;
					tally_n          = '0;
				end
			end
			phase_n = raw ? PH_PRS : PH_REL;
		end
		ev_c.stable_level = (phase_n == PH_PRS || phase_n == PH_REL_DB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_REL;
			debounce_q <= '0;
			hold_q     <= '0;
			repeat_q   <= '0;
			click_q    <= '0;
			tally_q    <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			debounce_q <= dc;
			hold_q     <= hold_n;
			repeat_q   <= repeat_n;
			click_q    <= click_n;
			tally_q    <= tally_n;
		end
	end

	assign ev = ev_c;

endmodule

`default_nettype wire

// File: rtl/button_event_detector_top.sv
// ---------------------------------------------------------------------------
// Button event detector top level
// Each sample passes through the input register and then the result register.
// Throughput: one sample per clock unless event_stall holds the result beat.
// The input register frees itself whenever the result register can take a beat.
// Reset clears pipeline valids and engine state and loads register defaults.
// ---------------------------------------------------------------------------
`default_nettype none
`include "button_event_detector_top_assert.svh"

module button_event_detector_top #(
	parameter int TIMER_WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bed_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bed_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            raw_valid,
	output logic                            raw_stall,
	input  logic                            raw_level,
	output logic                            event_valid,
	input  logic                            event_stall,
	output logic                            rising_edge,
	output logic                            falling_edge,
	output logic                            short_press,
	output logic [1:0]                      hold_mark,
	output logic [1:0]                      long_release,
	output logic                            repeat_press,
	output logic [1:0]                      click_event,
	output logic                            stable_level
);
	import bed_pkg::*;

	cfg_t   cfg;
	event_t ev_c;
	event_t ev_s2;
	logic   valid_s1, raw_s1, valid_s2;
	logic   load_s1, move_s1;

	assign cfg_ready = 1'b1;

	bed_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The input stage hands its beat on whenever the result register is free.
	assign move_s1   = valid_s1 && (!valid_s2 || !event_stall);
	assign raw_stall = valid_s1 && !move_s1;
	assign load_s1   = raw_valid && !raw_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) raw_s1 <= raw_level;
	end

	bed_engine #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (move_s1),
		.raw    (raw_s1),
		.cfg    (cfg),
		.ev     (ev_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (!event_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) ev_s2 <= ev_c;
	end

	assign event_valid  = valid_s2;
	assign rising_edge  = ev_s2.rising_edge;
	assign falling_edge = ev_s2.falling_edge;
	assign short_press  = ev_s2.short_press;
	assign hold_mark    = ev_s2.hold_mark;
	assign long_release = ev_s2.long_release;
	assign repeat_press = ev_s2.repeat_press;
	assign click_event  = ev_s2.click_event;
	assign stable_level = ev_s2.stable_level;

	`BED_ASSERT(a_stall_only_when_full, clk, arst_n, raw_stall |-> valid_s1)
	`BED_ASSERT(a_step_fills_result, clk, arst_n, move_s1 |=> event_valid)
	`BED_ASSERT_NEVER(a_edges_exclusive, clk, arst_n, event_valid && rising_edge && falling_edge)
	`BED_ASSERT_NEVER(a_release_class_exclusive, clk, arst_n,
		event_valid && short_press && (long_release != CLASS_NONE))

endmodule

`default_nettype wire

// File: verif/button_event_checker.sv
// ---------------------------------------------------------------------------
// Button event detector checker
// Watches the register, sample and event channels of the detector. Register
// writes update a private copy of the settings, every sample beat runs a
// model of the debounce, hold, repeat and click engines, and every event
// beat is compared field by field with the oldest predicted event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_event_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [bed_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bed_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            raw_valid,
	input  logic                            raw_stall,
	input  logic                            raw_level,
	input  logic                            event_valid,
	input  logic                            event_stall,
	input  logic                            rising_edge,
	input  logic                            falling_edge,
	input  logic                            short_press,
	input  logic [1:0]                      hold_mark,
	input  logic [1:0]                      long_release,
	input  logic                            repeat_press,
	input  logic [1:0]                      click_event,
	input  logic                            stable_level,
	output int                              mismatch_total,
	output int                              pending_events
);
	import bed_pkg::*;

	cfg_t       regs;
	phase_t     phase;
	logic [7:0] db_count;
	logic [7:0] hold_count;
	logic [7:0] repeat_count;
	logic [7:0] click_wait;
	logic [1:0] click_tally;

	event_t     expected_events[$];
	event_t     seen_event;
	event_t     next_event;
	int         mismatch_count;

	// One tick of the detector: updates the private state and returns the
	// event fields that the block must report for this sample.
	task automatic compute_events(input logic lvl, output event_t ev);
		logic [FEATURE_W-1:0] en;
		logic                 debouncing;
		logic                 pressed;
		logic                 held;
		logic                 released;
		phase_t               settled;
		en = regs.feature_enables;
		ev = '0;
		debouncing = 1'b0;
		if (en[EN_DEBOUNCE]) begin
			if (phase == PH_REL && lvl) begin
				phase = PH_PRS_DB;
				db_count = regs.debounce_ticks;
			end else if (phase == PH_PRS && !lvl) begin
				phase = PH_REL_DB;
				db_count = regs.debounce_ticks;
			end
			if (phase == PH_PRS_DB || phase == PH_REL_DB) begin
				settled = (phase == PH_PRS_DB) ? PH_REL : PH_PRS;
				if (lvl == (phase == PH_PRS_DB)) begin
					if (db_count != 8'd0) begin
						db_count = db_count - 8'd1;
						debouncing = 1'b1;
					end else begin
						// Stable long enough: fall through to the edge work below.
						phase = settled;
					end
				end else begin
					// The level bounced back before it settled.
					phase = settled;
					debouncing = 1'b1;
				end
			end
		end
		if (!debouncing) begin
			pressed  = (phase == PH_REL) && lvl;
			held     = (phase == PH_PRS) && lvl;
			released = (phase == PH_PRS) && !lvl;
			if (pressed) begin
				if (en[EN_MULTI])
					click_wait = regs.click_timeout;
				if (en[EN_EDGES])
					ev.rising_edge = 1'b1;
				if (en[EN_LONG])
					hold_count = 8'd0;
				if (en[EN_REPEAT]) begin
					ev.repeat_press = 1'b1;
					repeat_count = regs.repeat_delay;
				end
			end
			if (held) begin
				if (en[EN_MULTI])
					click_wait = regs.click_timeout;
				if (en[EN_LONG] && hold_count != 8'hFF)
					hold_count = hold_count + 8'd1;
				if (en[EN_REPEAT]) begin
					repeat_count = repeat_count - 8'd1;
					if (repeat_count == 8'd0) begin
						ev.repeat_press = 1'b1;
						repeat_count = regs.repeat_rate;
					end
				end
				if (en[EN_LONG]) begin
					if (hold_count == regs.long_threshold)
						ev.hold_mark = CLASS_LONG;
					else if (hold_count == regs.longer_threshold)
						ev.hold_mark = CLASS_LONGER;
					else if (hold_count == regs.longest_threshold)
						ev.hold_mark = CLASS_LONGEST;
				end
			end
			if (released) begin
				if (en[EN_MULTI]) begin
					click_wait = regs.click_timeout;
					if (click_tally < TALLY_MAX)
						click_tally = click_tally + 2'd1;
				end
				if (en[EN_EDGES])
					ev.falling_edge = 1'b1;
				if (en[EN_LONG]) begin
					if (hold_count < regs.long_threshold)
						ev.short_press = 1'b1;
					else if (hold_count < regs.longer_threshold)
						ev.long_release = CLASS_LONG;
					else if (hold_count < regs.longest_threshold)
						ev.long_release = CLASS_LONGER;
					else
						ev.long_release = CLASS_LONGEST;
				end else if (en[EN_SINGLE]) begin
					ev.short_press = 1'b1;
				end
			end
			if (en[EN_MULTI]) begin
				if (click_wait != 8'd0) begin
					click_wait = click_wait - 8'd1;
				end else begin
					ev.click_event = click_tally;
					click_tally = 2'd0;
				end
			end
			phase = lvl ? PH_PRS : PH_REL;
		end
		ev.stable_level = (phase == PH_PRS) || (phase == PH_REL_DB);
	endtask

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	assign seen_event = '{rising_edge, falling_edge, short_press, hold_mark, long_release,
		repeat_press, click_event, stable_level};

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.debounce_ticks    = RST_DEBOUNCE_TICKS;
			regs.click_timeout     = RST_CLICK_TIMEOUT;
			regs.repeat_delay      = RST_REPEAT_DELAY;
			regs.repeat_rate       = RST_REPEAT_RATE;
			regs.long_threshold    = RST_LONG_THRESHOLD;
			regs.longer_threshold  = RST_LONGER_THRESHOLD;
			regs.longest_threshold = RST_LONGEST_THRESHOLD;
			regs.feature_enables   = RST_FEATURE_ENABLES;
			phase        = PH_REL;
			db_count     = 8'd0;
			hold_count   = 8'd0;
			repeat_count = 8'd0;
			click_wait   = 8'd0;
			click_tally  = 2'd0;
			expected_events.delete();
			mismatch_count = 0;
			mismatch_total <= 0;
			pending_events <= 0;
		end else begin
			// The event beat of this edge always belongs to an older sample.
			if (event_valid && !event_stall) begin
				if (expected_events.size() == 0) begin
					$display("%0t: event beat with no sample waiting, actual %h", $time,
						seen_event);
					mismatch_count++;
				end else begin
					next_event = expected_events.pop_front();
					check_field("rising_edge", 2'(next_event.rising_edge), 2'(rising_edge));
					check_field("falling_edge", 2'(next_event.falling_edge),
						2'(falling_edge));
					check_field("short_press", 2'(next_event.short_press), 2'(short_press));
					check_field("hold_mark", next_event.hold_mark, hold_mark);
					check_field("long_release", next_event.long_release, long_release);
					check_field("repeat_press", 2'(next_event.repeat_press),
						2'(repeat_press));
					check_field("click_event", next_event.click_event, click_event);
					check_field("stable_level", 2'(next_event.stable_level),
						2'(stable_level));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEBOUNCE_TICKS:    regs.debounce_ticks    = cfg_data;
					CFG_CLICK_TIMEOUT:     regs.click_timeout     = cfg_data;
					CFG_REPEAT_DELAY:      regs.repeat_delay      = cfg_data;
					CFG_REPEAT_RATE:       regs.repeat_rate       = cfg_data;
					CFG_LONG_THRESHOLD:    regs.long_threshold    = cfg_data;
					CFG_LONGER_THRESHOLD:  regs.longer_threshold  = cfg_data;
					CFG_LONGEST_THRESHOLD: regs.longest_threshold = cfg_data;
					CFG_FEATURE_ENABLES:   regs.feature_enables   = cfg_data[FEATURE_W-1:0];
					default: ;
				endcase
			end
			if (raw_valid && !raw_stall) begin
				compute_events(raw_level, next_event);
				expected_events.push_back(next_event);
			end
			mismatch_total <= mismatch_count;
			pending_events <= expected_events.size();
		end
	end

endmodule

// File: verif/button_event_detector_top_tb.sv
// ---------------------------------------------------------------------------
// Button event detector testbench
// Drives button sample streams through the detector under several register
// settings, from short directed sequences to randomized presses, bounces and
// click bursts, with random idling on both channels. A checker beside the
// block predicts and compares every event beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_event_detector_top_tb;
	import bed_pkg::*;

	// Directed burst under fast settings: a bounce back, an accepted press, a
	// short hold across equal thresholds, three more quick clicks and the timeout.
	localparam logic [23:0] DIRECTED_BURST = 24'b1011_1110_0110_0110_0110_0000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   raw_valid = 1'b0;
	logic                   raw_stall;
	logic                   raw_level = 1'b0;
	logic                   event_valid;
	logic                   event_stall = 1'b0;
	logic                   rising_edge;
	logic                   falling_edge;
	logic                   short_press;
	logic [1:0]             hold_mark;
	logic [1:0]             long_release;
	logic                   repeat_press;
	logic [1:0]             click_event;
	logic                   stable_level;
	int                     mismatch_total;
	int                     pending_events;

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   ticks_sent = 0;
	cfg_t active_cfg;

	always #6 clk = ~clk;

	always @(posedge clk)
		event_stall <= ($urandom_range(99) < recv_stall_pct);

	button_event_detector_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.raw_valid    (raw_valid),
		.raw_stall    (raw_stall),
		.raw_level    (raw_level),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.rising_edge  (rising_edge),
		.falling_edge (falling_edge),
		.short_press  (short_press),
		.hold_mark    (hold_mark),
		.long_release (long_release),
		.repeat_press (repeat_press),
		.click_event  (click_event),
		.stable_level (stable_level)
	);

	button_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.raw_valid      (raw_valid),
		.raw_stall      (raw_stall),
		.raw_level      (raw_level),
		.event_valid    (event_valid),
		.event_stall    (event_stall),
		.rising_edge    (rising_edge),
		.falling_edge   (falling_edge),
		.short_press    (short_press),
		.hold_mark      (hold_mark),
		.long_release   (long_release),
		.repeat_press   (repeat_press),
		.click_event    (click_event),
		.stable_level   (stable_level),
		.mismatch_total (mismatch_total),
		.pending_events (pending_events)
	);

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 22;
				recv_stall_pct = 51;
			end
			1: begin
				send_idle_pct = 51;
				recv_stall_pct = 22;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic send_tick(input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			raw_valid <= 1'b0;
			@(posedge clk);
		end
		raw_valid <= 1'b1;
		raw_level <= lvl;
		@(posedge clk);
		while (raw_stall)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic send_run(input logic lvl, input int count);
		repeat (count)
			send_tick(lvl);
	endtask

	// The checker's count is registered, so wait past the last beat before reading it.
	task automatic wait_drained();
		raw_valid <= 1'b0;
		@(posedge clk);
		while (pending_events != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		wait_drained();
		write_reg(CFG_DEBOUNCE_TICKS, c.debounce_ticks);
		write_reg(CFG_CLICK_TIMEOUT, c.click_timeout);
		write_reg(CFG_REPEAT_DELAY, c.repeat_delay);
		write_reg(CFG_REPEAT_RATE, c.repeat_rate);
		write_reg(CFG_LONG_THRESHOLD, c.long_threshold);
		write_reg(CFG_LONGER_THRESHOLD, c.longer_threshold);
		write_reg(CFG_LONGEST_THRESHOLD, c.longest_threshold);
		// The unused top bits of the mask beat carry random values.
		write_reg(CFG_FEATURE_ENABLES, {2'($urandom_range(3)), c.feature_enables});
		cfg_valid <= 1'b0;
		active_cfg = c;
	endtask

	function automatic cfg_t uniform_cfg(input logic [7:0] val, input logic [FEATURE_W-1:0] mask);
		cfg_t c;
		c.debounce_ticks    = val;
		c.click_timeout     = val;
		c.repeat_delay      = val;
		c.repeat_rate       = val;
		c.long_threshold    = val;
		c.longer_threshold  = val;
		c.longest_threshold = val;
		c.feature_enables   = mask;
		return c;
	endfunction

	function automatic cfg_t fast_random_cfg();
		cfg_t       c;
		logic [7:0] swap;
		c.debounce_ticks    = 8'($urandom_range(0, 4));
		c.click_timeout     = 8'($urandom_range(0, 12));
		c.repeat_delay      = 8'($urandom_range(1, 8));
		c.repeat_rate       = 8'($urandom_range(1, 6));
		c.long_threshold    = 8'($urandom_range(0, 20));
		c.longer_threshold  = c.long_threshold + 8'($urandom_range(0, 10));
		c.longest_threshold = c.longer_threshold + 8'($urandom_range(0, 10));
		// Now and then the thresholds come out of order.
		if ($urandom_range(3) == 0) begin
			swap = c.long_threshold;
			c.long_threshold = c.longest_threshold;
			c.longest_threshold = swap;
		end
		c.feature_enables = ($urandom_range(2) == 0) ? FEATURE_W'($urandom_range(63)) : 6'h3F;
		return c;
	endfunction

	// Mostly well-formed presses with random hold and gap lengths, some
	// with bounces at either end, mixed with short runs of pure noise.
	task automatic run_random(input int budget);
		int stop_at;
		int span;
		int db;
		int hold;
		int gap;
		stop_at = ticks_sent + budget;
		db = int'(active_cfg.debounce_ticks);
		span = int'(active_cfg.long_threshold);
		if (int'(active_cfg.longer_threshold) > span)
			span = int'(active_cfg.longer_threshold);
		if (int'(active_cfg.longest_threshold) > span)
			span = int'(active_cfg.longest_threshold);
		if (int'(active_cfg.repeat_delay) > span)
			span = int'(active_cfg.repeat_delay);
		span = span + 4;
		if (span > 210)
			span = 210;
		while (ticks_sent < stop_at) begin
			if (db > 16 || $urandom_range(7) == 0) begin
				repeat ($urandom_range(1, 6))
					send_tick(1'($urandom_range(1)));
			end else begin
				if ($urandom_range(2) == 0) begin
					send_tick(1'b1);
					send_tick(1'b0);
				end
				hold = ($urandom_range(1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, span);
				send_run(1'b1, db + 1 + hold);
				if ($urandom_range(2) == 0) begin
					send_tick(1'b0);
					send_tick(1'b1);
				end
				gap = ($urandom_range(1) != 0) ? $urandom_range(0, 2) :
					$urandom_range(0, int'(active_cfg.click_timeout) + 3);
				send_run(1'b0, db + 1 + gap);
			end
			if ($urandom_range(15) == 0)
				wait_drained();
		end
	endtask

	initial begin
		cfg_t c;
		active_cfg = '{RST_DEBOUNCE_TICKS, RST_CLICK_TIMEOUT, RST_REPEAT_DELAY,
			RST_REPEAT_RATE, RST_LONG_THRESHOLD, RST_LONGER_THRESHOLD,
			RST_LONGEST_THRESHOLD, RST_FEATURE_ENABLES};
		set_idling(0);
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fast settings with equal long and longer thresholds.
		c = '{8'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 6'h3F};
		program_regs(c);
		for (int k = 23; k >= 0; k--)
			send_tick(DIRECTED_BURST[k]);

		// Directed: debounce switched off while a press is still settling.
		c = '{8'd3, 8'd2, 8'd2, 8'd1, 8'd2, 8'd3, 8'd4, 6'h3F};
		program_regs(c);
		send_tick(1'b1);
		c.feature_enables[EN_DEBOUNCE] = 1'b0;
		program_regs(c);
		send_tick(1'b0);
		send_run(1'b1, 3);
		send_run(1'b0, 3);

		// Reset values, restored by writing them back.
		c = '{RST_DEBOUNCE_TICKS, RST_CLICK_TIMEOUT, RST_REPEAT_DELAY, RST_REPEAT_RATE,
			RST_LONG_THRESHOLD, RST_LONGER_THRESHOLD, RST_LONGEST_THRESHOLD,
			RST_FEATURE_ENABLES};
		program_regs(c);
		run_random(60);

		for (int p = 0; p < 6; p++) begin
			set_idling(p / 2);
			program_regs(fast_random_cfg());
			run_random(40);
			if (p == 3) begin
				program_regs(uniform_cfg(8'd0, 6'h00));
				run_random(20);
				program_regs(uniform_cfg(8'd0, 6'h3F));
				run_random(30);
				program_regs(uniform_cfg(8'hFF, 6'h3F));
				run_random(20);
			end
		end

		// Hold saturation and a wrapped repeat counter during one long hold.
		c = '{8'd0, 8'd20, 8'd0, 8'd0, 8'd253, 8'd254, 8'd255, 6'h3F};
		program_regs(c);
		send_run(1'b1, 261);
		send_run(1'b0, 30);

		wait_drained();
		repeat (8)
			@(posedge clk);
		if (mismatch_total == 0 && pending_events == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/bed_pkg.sv
rtl/bed_cfg_regs.sv
rtl/bed_engine.sv
rtl/button_event_detector_top.sv
verif/button_event_checker.sv
verif/button_event_detector_top_tb.sv
